### hw/rtl/a64dec_pkg.sv
// ============================================================================
// a64dec_pkg: shared types and encodings for the AArch64 subset decoder
// Holds the mnemonic class codes, addressing modes, match masks and the
// decoded result record passed from the decode logic to the top level.
// ============================================================================
package a64dec_pkg;

    typedef enum logic [5:0] {
        OP_ADR    = 6'd0,
        OP_ADRP   = 6'd1,
        OP_B      = 6'd2,
        OP_BL     = 6'd3,
        OP_BCOND  = 6'd4,
        OP_CBZ    = 6'd5,
        OP_CBNZ   = 6'd6,
        OP_TBZ    = 6'd7,
        OP_TBNZ   = 6'd8,
        OP_RET    = 6'd9,
        OP_BR     = 6'd10,
        OP_BLR    = 6'd11,
        OP_ADD    = 6'd12,
        OP_SUB    = 6'd13,
        OP_AND    = 6'd14,
        OP_ORR    = 6'd15,
        OP_EOR    = 6'd16,
        OP_CSEL   = 6'd17,
        OP_CSINV  = 6'd18,
        OP_MOVN   = 6'd19,
        OP_MOVZ   = 6'd20,
        OP_MOVK   = 6'd21,
        OP_STUR   = 6'd22,
        OP_LDUR   = 6'd23,
        OP_STR    = 6'd24,
        OP_LDR    = 6'd25,
        OP_STP    = 6'd26,
        OP_LDP    = 6'd27,
        OP_MUL    = 6'd28,
        OP_UDIV   = 6'd29,
        OP_SDIV   = 6'd30,
        OP_NOP    = 6'd31,
        OP_SVC    = 6'd32,
        OP_BRK    = 6'd33,
        OP_WFE    = 6'd34,
        OP_WFI    = 6'd35,
        OP_DMB    = 6'd36,
        OP_DSB    = 6'd37,
        OP_ISB    = 6'd38,
        OP_OPAQUE = 6'd39
    } op_class_t;

    typedef enum logic [1:0] {
        AM_NONE   = 2'd0,
        AM_OFFSET = 2'd1,
        AM_PRE    = 2'd2,
        AM_POST   = 2'd3
    } addr_mode_t;

    // Index field codes of the unscaled and pair load/store forms
    localparam logic [1:0] IX_POST = 2'b01;
    localparam logic [1:0] IX_PRE  = 2'b11;

    // Logical and move-wide opc codes
    localparam logic [1:0] OPC_0 = 2'd0;
    localparam logic [1:0] OPC_1 = 2'd1;
    localparam logic [1:0] OPC_2 = 2'd2;

    // Encoding masks and match values, in priority order
    localparam logic [31:0] MSK_ADR    = 32'h1F00_0000;
    localparam logic [31:0] VAL_ADR    = 32'h1000_0000;
    localparam logic [31:0] MSK_B      = 32'h7C00_0000;
    localparam logic [31:0] VAL_B      = 32'h1400_0000;
    localparam logic [31:0] MSK_BCOND  = 32'hFF00_0010;
    localparam logic [31:0] VAL_BCOND  = 32'h5400_0000;
    localparam logic [31:0] MSK_CB     = 32'h7E00_0000;
    localparam logic [31:0] VAL_CB     = 32'h3400_0000;
    localparam logic [31:0] VAL_TB     = 32'h3600_0000;
    localparam logic [31:0] MSK_BRREG  = 32'hFFFF_FC1F;
    localparam logic [31:0] VAL_RET    = 32'hD65F_0000;
    localparam logic [31:0] VAL_BR     = 32'hD61F_0000;
    localparam logic [31:0] VAL_BLR    = 32'hD63F_0000;
    localparam logic [31:0] VAL_ADDI   = 32'h1100_0000;
    localparam logic [31:0] MSK_ALUREG = 32'h1F20_0000;
    localparam logic [31:0] VAL_ADDR   = 32'h0B00_0000;
    localparam logic [31:0] VAL_LOGIC  = 32'h0A00_0000;
    localparam logic [31:0] MSK_CSEL   = 32'h1FE0_0000;
    localparam logic [31:0] VAL_CSEL   = 32'h1A80_0000;
    localparam logic [31:0] MSK_MOVW   = 32'h1F80_0000;
    localparam logic [31:0] VAL_MOVW   = 32'h1280_0000;
    localparam logic [31:0] MSK_LDUR   = 32'h3B20_0000;
    localparam logic [31:0] VAL_LDUR   = 32'h3800_0000;
    localparam logic [31:0] MSK_LDR    = 32'h3B00_0000;
    localparam logic [31:0] VAL_LDR    = 32'h3900_0000;
    localparam logic [31:0] MSK_LDP    = 32'h3A00_0000;
    localparam logic [31:0] VAL_LDP    = 32'h2800_0000;
    localparam logic [31:0] MSK_MULDIV = 32'hFFE0_FC00;
    localparam logic [31:0] VAL_MUL    = 32'h9B00_7C00;
    localparam logic [31:0] VAL_SDIV   = 32'h9AC0_0C00;
    localparam logic [31:0] VAL_UDIV   = 32'h9AC0_0800;
    localparam logic [31:0] WORD_WFE   = 32'hD503_205F;
    localparam logic [31:0] WORD_WFI   = 32'hD503_207F;
    localparam logic [31:0] VAL_HINT   = 32'hD503_201F;
    localparam logic [31:0] MSK_EXC    = 32'hFFE0_001F;
    localparam logic [31:0] VAL_SVC    = 32'hD400_0001;
    localparam logic [31:0] VAL_BRK    = 32'hD420_0000;
    localparam logic [31:0] WORD_DMB   = 32'hD503_3BBF;
    localparam logic [31:0] WORD_DSB   = 32'hD503_3F9F;
    localparam logic [31:0] WORD_ISB   = 32'hD503_3FDF;

    typedef struct packed {
        op_class_t          op_class;
        logic [4:0]         dest_reg;
        logic [4:0]         base_reg;
        logic [4:0]         second_reg;
        logic [3:0]         operand_bytes;
        logic [3:0]         cond_code;
        logic [63:0]        imm_value;
        logic               target_valid;
        logic [63:0]        target_addr;
        logic signed [15:0] mem_disp;
        addr_mode_t         addr_mode;
        logic               reencodable;
    } dec_result_t;

endpackage

### hw/rtl/a64dec_decode.sv
// ============================================================================
// a64dec_decode: single-word AArch64 subset decode
// Matches one instruction word against the ordered encoding list, extracts
// the fields and forms the PC-relative target with one 64-bit adder.
// ============================================================================
module a64dec_decode
    import a64dec_pkg::*;
(
    input  logic [31:0]  instr_word,
    input  logic [63:0]  pc_address,
    output dec_result_t  result
);

    logic        sf;
    logic [3:0]  reg_bytes;
    logic [63:0] tgt_base;
    logic [63:0] tgt_off;
    logic [15:0] uimm16;

    assign sf        = instr_word[31];
    assign reg_bytes = sf ? 4'd8 : 4'd4;
    assign uimm16    = instr_word[20:5];

    always_comb begin
        result               = '0;
        result.op_class      = OP_OPAQUE;
        result.dest_reg      = instr_word[4:0];
        result.base_reg      = instr_word[9:5];
        result.second_reg    = instr_word[20:16];
        result.operand_bytes = 4'd4;
        result.addr_mode     = AM_NONE;
        tgt_base             = '0;
        tgt_off              = '0;

        if ((instr_word & MSK_ADR) == VAL_ADR) begin
            result.operand_bytes = 4'd8;
            result.target_valid  = 1'b1;
            if (sf) begin
                // adrp: page base plus page offset
                result.op_class = OP_ADRP;
                tgt_base = {pc_address[63:12], 12'h000};
                tgt_off  = {{31{instr_word[23]}}, instr_word[23:5],
                            instr_word[30:29], 12'h000};
            end else begin
                result.op_class = OP_ADR;
                tgt_base = pc_address;
                tgt_off  = {{43{instr_word[23]}}, instr_word[23:5], instr_word[30:29]};
            end
        end else if ((instr_word & MSK_B) == VAL_B) begin
            result.op_class     = sf ? OP_BL : OP_B;
            result.target_valid = 1'b1;
            tgt_base = pc_address;
            tgt_off  = {{36{instr_word[25]}}, instr_word[25:0], 2'b00};
        end else if ((instr_word & MSK_BCOND) == VAL_BCOND) begin
            result.op_class     = OP_BCOND;
            result.cond_code    = instr_word[3:0];
            result.target_valid = 1'b1;
            tgt_base = pc_address;
            tgt_off  = {{43{instr_word[23]}}, instr_word[23:5], 2'b00};
        end else if ((instr_word & MSK_CB) == VAL_CB) begin
            result.op_class      = instr_word[24] ? OP_CBNZ : OP_CBZ;
            result.operand_bytes = reg_bytes;
            result.target_valid  = 1'b1;
            tgt_base = pc_address;
            tgt_off  = {{43{instr_word[23]}}, instr_word[23:5], 2'b00};
        end else if ((instr_word & MSK_CB) == VAL_TB) begin
            result.op_class      = instr_word[24] ? OP_TBNZ : OP_TBZ;
            result.operand_bytes = reg_bytes;
            result.imm_value     = {58'd0, sf, instr_word[23:19]};
            result.target_valid  = 1'b1;
            tgt_base = pc_address;
            tgt_off  = {{48{instr_word[18]}}, instr_word[18:5], 2'b00};
        end else if ((instr_word & MSK_BRREG) == VAL_RET) begin
            result.op_class      = OP_RET;
            result.operand_bytes = 4'd8;
        end else if ((instr_word & MSK_BRREG) == VAL_BR) begin
            result.op_class      = OP_BR;
            result.operand_bytes = 4'd8;
        end else if ((instr_word & MSK_BRREG) == VAL_BLR) begin
            result.op_class      = OP_BLR;
            result.operand_bytes = 4'd8;
        end else if ((instr_word & MSK_ADR) == VAL_ADDI) begin
            result.op_class      = instr_word[30] ? OP_SUB : OP_ADD;
            result.operand_bytes = reg_bytes;
            result.imm_value     = {52'd0, instr_word[21:10]};
        end else if ((instr_word & MSK_ALUREG) == VAL_ADDR) begin
            result.op_class      = instr_word[30] ? OP_SUB : OP_ADD;
            result.operand_bytes = reg_bytes;
        end else if ((instr_word & MSK_ALUREG) == VAL_LOGIC) begin
            case (instr_word[30:29])
                OPC_1:   result.op_class = OP_ORR;
                OPC_2:   result.op_class = OP_EOR;
                default: result.op_class = OP_AND;
            endcase
            result.operand_bytes = reg_bytes;
        end else if ((instr_word & MSK_CSEL) == VAL_CSEL) begin
            result.op_class      = instr_word[30] ? OP_CSINV : OP_CSEL;
            result.operand_bytes = reg_bytes;
            result.cond_code     = instr_word[15:12];
        end else if ((instr_word & MSK_MOVW) == VAL_MOVW && instr_word[30:29] != OPC_1) begin
            case (instr_word[30:29])
                OPC_0:   result.op_class = OP_MOVN;
                OPC_2:   result.op_class = OP_MOVZ;
                default: result.op_class = OP_MOVK;
            endcase
            result.operand_bytes = reg_bytes;
            case (instr_word[22:21])
                2'd0:    result.imm_value = {48'd0, uimm16};
                2'd1:    result.imm_value = {32'd0, uimm16, 16'd0};
                2'd2:    result.imm_value = {16'd0, uimm16, 32'd0};
                default: result.imm_value = {uimm16, 48'd0};
            endcase
        end else if ((instr_word & MSK_LDUR) == VAL_LDUR) begin
            result.op_class      = instr_word[22] ? OP_LDUR : OP_STUR;
            result.operand_bytes = 4'd1 << instr_word[31:30];
            result.mem_disp      = {{7{instr_word[20]}}, instr_word[20:12]};
            case (instr_word[11:10])
                IX_POST: result.addr_mode = AM_POST;
                IX_PRE:  result.addr_mode = AM_PRE;
                default: result.addr_mode = AM_OFFSET;
            endcase
        end else if ((instr_word & MSK_LDR) == VAL_LDR) begin
            result.op_class      = instr_word[22] ? OP_LDR : OP_STR;
            result.operand_bytes = 4'd1 << instr_word[31:30];
            result.mem_disp      = {4'd0, instr_word[21:10]} << instr_word[31:30];
            result.addr_mode     = AM_OFFSET;
        end else if ((instr_word & MSK_LDP) == VAL_LDP) begin
            result.op_class      = instr_word[22] ? OP_LDP : OP_STP;
            result.operand_bytes = reg_bytes;
            result.second_reg    = instr_word[14:10];
            // scale the pair offset by the register width
            result.mem_disp      = {{9{instr_word[21]}}, instr_word[21:15]}
                                   << (sf ? 2'd3 : 2'd2);
            case (instr_word[24:23])
                IX_POST: result.addr_mode = AM_POST;
                IX_PRE:  result.addr_mode = AM_PRE;
                default: result.addr_mode = AM_OFFSET;
            endcase
        end else if ((instr_word & MSK_MULDIV) == VAL_MUL) begin
            result.op_class      = OP_MUL;
            result.operand_bytes = reg_bytes;
        end else if ((instr_word & MSK_MULDIV) == VAL_SDIV) begin
            result.op_class      = OP_SDIV;
            result.operand_bytes = reg_bytes;
        end else if ((instr_word & MSK_MULDIV) == VAL_UDIV) begin
            result.op_class      = OP_UDIV;
            result.operand_bytes = reg_bytes;
        end else if (instr_word == WORD_WFE) begin
            result.op_class = OP_WFE;
        end else if (instr_word == WORD_WFI) begin
            result.op_class = OP_WFI;
        end else if ((instr_word & MSK_BRREG) == VAL_HINT) begin
            result.op_class = OP_NOP;
        end else if ((instr_word & MSK_EXC) == VAL_SVC) begin
            result.op_class  = OP_SVC;
            result.imm_value = {48'd0, uimm16};
        end else if ((instr_word & MSK_EXC) == VAL_BRK) begin
            result.op_class  = OP_BRK;
            result.imm_value = {48'd0, uimm16};
        end else if (instr_word == WORD_DMB) begin
            result.op_class = OP_DMB;
        end else if (instr_word == WORD_DSB) begin
            result.op_class = OP_DSB;
        end else if (instr_word == WORD_ISB) begin
            result.op_class = OP_ISB;
        end

        result.target_addr = tgt_base + tgt_off;
        result.reencodable = (result.op_class != OP_OPAQUE);
    end

endmodule

### hw/rtl/arm64_instruction_decoder_top.sv
// ============================================================================
// arm64_instruction_decoder_top: AArch64 subset instruction decoder
// Decodes one instruction word per cycle, unless m_ready stalls, into class,
// register fields, immediates, PC-relative target and load/store addressing.
// ============================================================================
//
//  Channel  Direction  Handshake           Payload
//  -------  ---------  ------------------  -----------------------------------
//  s_       in         s_valid / s_ready   s_instr_word, s_pc_address
//  m_       out        m_valid / m_ready   m_op_class ... m_reencodable
//
//  - A request is captured in the input register at its accepting edge and
//    decoded into the result register once the result stage can advance;
//    m_valid rises when the result register is loaded.
//  - One request per cycle while m_ready is high; the only logic between the
//    two registers is mask match, field muxing and one 64-bit target adder.
//  - aresetn (synchronous, active low) clears both valid flags only.
//  - When m_ready is low the result register holds; the input register still
//    takes one more request if it is empty, so s_ready drops only when both
//    stages are full.
//
module arm64_instruction_decoder_top
    import a64dec_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [31:0]        s_instr_word,
    input  logic [63:0]        s_pc_address,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_op_class,
    output logic [4:0]         m_dest_reg,
    output logic [4:0]         m_base_reg,
    output logic [4:0]         m_second_reg,
    output logic [3:0]         m_operand_bytes,
    output logic [3:0]         m_cond_code,
    output logic [63:0]        m_imm_value,
    output logic               m_target_valid,
    output logic [63:0]        m_target_addr,
    output logic signed [15:0] m_mem_disp,
    output logic [1:0]         m_addr_mode,
    output logic               m_reencodable
);

    // Input stage
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] word_reg;
    logic [63:0] pc_reg;

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_result_t res_reg;
    dec_result_t dec_result;

    logic advance;
    logic s_fire;

    // Move the result stage when it is empty or being drained
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    a64dec_decode u_decode (
        .instr_word (word_reg),
        .pc_address (pc_reg),
        .result     (dec_result)
    );

    always_comb begin
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            word_reg <= s_instr_word;
            pc_reg   <= s_pc_address;
        end
        if (advance && in_valid_reg) begin
            res_reg <= dec_result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_op_class      = res_reg.op_class;
    assign m_dest_reg      = res_reg.dest_reg;
    assign m_base_reg      = res_reg.base_reg;
    assign m_second_reg    = res_reg.second_reg;
    assign m_operand_bytes = res_reg.operand_bytes;
    assign m_cond_code     = res_reg.cond_code;
    assign m_imm_value     = res_reg.imm_value;
    assign m_target_valid  = res_reg.target_valid;
    assign m_target_addr   = res_reg.target_addr;
    assign m_mem_disp      = res_reg.mem_disp;
    assign m_addr_mode     = res_reg.addr_mode;
    assign m_reencodable   = res_reg.reencodable;

    // A filled input stage reaches the output once the result stage frees up
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && advance |=> m_valid)
        else $error("decoded request did not reach the result stage");

    // Only the opaque class is flagged as not re-encodable
    a_reenc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reencodable == (res_reg.op_class != OP_OPAQUE)))
        else $error("reencodable flag disagrees with class");

    // Targets come only from the PC-relative classes
    a_target_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_target_valid |-> (res_reg.op_class <= OP_TBNZ))
        else $error("target flagged for a non PC-relative class");

    // Memory addressing only on load/store classes
    a_mem_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (res_reg.addr_mode != AM_NONE)
            |-> (res_reg.op_class >= OP_STUR && res_reg.op_class <= OP_LDP))
        else $error("addressing mode set on a non-memory class");

    // Access width is always a single power of two
    a_bytes_pow2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot(m_operand_bytes))
        else $error("operand width is not 1, 2, 4 or 8 bytes");

endmodule

### tb/sv/a64dec_tb_pkg.sv
`timescale 1ns / 100ps
// ============================================================================
// a64dec_tb_pkg: decode scoreboard for the AArch64 subset decoder bench
// Predicts the decoded record of every accepted instruction word, queues it
// in request order and compares each delivered result field by field.
// ============================================================================
package a64dec_tb_pkg;

    import a64dec_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [63:0] pc;
        dec_result_t want;
    } decode_entry_t;

    class decode_scoreboard;

        localparam int unsigned MAX_REPORTED = 100;

        decode_entry_t pending_decodes[$];
        int unsigned   n_requests;
        int unsigned   n_checked;
        int unsigned   n_errors;
        bit            class_seen[40];

        // Sign-extend the low bits of v to 64 bits.
        function logic [63:0] sext(logic [63:0] v, int unsigned bits);
            logic [63:0] m;
            m = 64'd1 << (bits - 1);
            v = v & ((64'd1 << bits) - 64'd1);
            return (v ^ m) - m;
        endfunction

        // First matching encoding wins; unmatched words stay opaque.
        function dec_result_t decode_a64(logic [31:0] w, logic [63:0] pc);
            dec_result_t r;
            logic [63:0] regw;
            logic [63:0] off;
            logic [63:0] disp;
            logic [1:0]  ix;
            r = '0;
            r.op_class      = OP_OPAQUE;
            r.dest_reg      = w[4:0];
            r.base_reg      = w[9:5];
            r.second_reg    = w[20:16];
            r.operand_bytes = 4'd4;
            regw = w[31] ? 64'd8 : 64'd4;
            disp = '0;
            ix   = '0;
            if ((w & MSK_ADR) == VAL_ADR) begin
                off = sext({w[23:5], w[30:29]}, 21);
                if (w[31]) begin
                    r.op_class    = OP_ADRP;
                    r.target_addr = (pc & ~64'hFFF) + (off << 12);
                end else begin
                    r.op_class    = OP_ADR;
                    r.target_addr = pc + off;
                end
                r.operand_bytes = 4'd8;
                r.target_valid  = 1'b1;
            end else if ((w & MSK_B) == VAL_B) begin
                r.op_class     = w[31] ? OP_BL : OP_B;
                r.target_addr  = pc + (sext(w[25:0], 26) << 2);
                r.target_valid = 1'b1;
            end else if ((w & MSK_BCOND) == VAL_BCOND) begin
                r.op_class     = OP_BCOND;
                r.cond_code    = w[3:0];
                r.target_addr  = pc + (sext(w[23:5], 19) << 2);
                r.target_valid = 1'b1;
            end else if ((w & MSK_CB) == VAL_CB) begin
                r.op_class      = w[24] ? OP_CBNZ : OP_CBZ;
                r.operand_bytes = regw[3:0];
                r.target_addr   = pc + (sext(w[23:5], 19) << 2);
                r.target_valid  = 1'b1;
            end else if ((w & MSK_CB) == VAL_TB) begin
                r.op_class      = w[24] ? OP_TBNZ : OP_TBZ;
                r.operand_bytes = regw[3:0];
                r.imm_value     = {58'd0, w[31], w[23:19]};
                r.target_addr   = pc + (sext(w[18:5], 14) << 2);
                r.target_valid  = 1'b1;
            end else if ((w & MSK_BRREG) == VAL_RET) begin
                r.op_class      = OP_RET;
                r.operand_bytes = 4'd8;
            end else if ((w & MSK_BRREG) == VAL_BR) begin
                r.op_class      = OP_BR;
                r.operand_bytes = 4'd8;
            end else if ((w & MSK_BRREG) == VAL_BLR) begin
                r.op_class      = OP_BLR;
                r.operand_bytes = 4'd8;
            end else if ((w & MSK_ADR) == VAL_ADDI) begin
                r.op_class      = w[30] ? OP_SUB : OP_ADD;
                r.operand_bytes = regw[3:0];
                r.imm_value     = 64'(w[21:10]);
            end else if ((w & MSK_ALUREG) == VAL_ADDR) begin
                r.op_class      = w[30] ? OP_SUB : OP_ADD;
                r.operand_bytes = regw[3:0];
            end else if ((w & MSK_ALUREG) == VAL_LOGIC) begin
                r.op_class      = (w[30:29] == OPC_1) ? OP_ORR :
                                  (w[30:29] == OPC_2) ? OP_EOR : OP_AND;
                r.operand_bytes = regw[3:0];
            end else if ((w & MSK_CSEL) == VAL_CSEL) begin
                r.op_class      = w[30] ? OP_CSINV : OP_CSEL;
                r.operand_bytes = regw[3:0];
                r.cond_code     = w[15:12];
            end else if ((w & MSK_MOVW) == VAL_MOVW && w[30:29] != OPC_1) begin
                r.op_class      = (w[30:29] == OPC_0) ? OP_MOVN :
                                  (w[30:29] == OPC_2) ? OP_MOVZ : OP_MOVK;
                r.operand_bytes = regw[3:0];
                r.imm_value     = 64'(w[20:5]) << (16 * w[22:21]);
            end else if ((w & MSK_LDUR) == VAL_LDUR) begin
                ix = w[11:10];
                r.op_class      = w[22] ? OP_LDUR : OP_STUR;
                r.operand_bytes = 4'(1 << w[31:30]);
                disp            = sext(w[20:12], 9);
                r.addr_mode     = (ix == IX_POST) ? AM_POST :
                                  (ix == IX_PRE)  ? AM_PRE  : AM_OFFSET;
            end else if ((w & MSK_LDR) == VAL_LDR) begin
                r.op_class      = w[22] ? OP_LDR : OP_STR;
                r.operand_bytes = 4'(1 << w[31:30]);
                disp            = 64'(w[21:10]) << w[31:30];
                r.addr_mode     = AM_OFFSET;
            end else if ((w & MSK_LDP) == VAL_LDP) begin
                ix = w[24:23];
                r.op_class      = w[22] ? OP_LDP : OP_STP;
                r.operand_bytes = regw[3:0];
                disp            = sext(w[21:15], 7) * regw;
                r.addr_mode     = (ix == IX_POST) ? AM_POST :
                                  (ix == IX_PRE)  ? AM_PRE  : AM_OFFSET;
                r.second_reg    = w[14:10];
            end else if ((w & MSK_MULDIV) == VAL_MUL) begin
                r.op_class      = OP_MUL;
                r.operand_bytes = regw[3:0];
            end else if ((w & MSK_MULDIV) == VAL_SDIV) begin
                r.op_class      = OP_SDIV;
                r.operand_bytes = regw[3:0];
            end else if ((w & MSK_MULDIV) == VAL_UDIV) begin
                r.op_class      = OP_UDIV;
                r.operand_bytes = regw[3:0];
            end else if (w == WORD_WFE) begin
                r.op_class = OP_WFE;
            end else if (w == WORD_WFI) begin
                r.op_class = OP_WFI;
            end else if ((w & MSK_BRREG) == VAL_HINT) begin
                r.op_class = OP_NOP;
            end else if ((w & MSK_EXC) == VAL_SVC) begin
                r.op_class  = OP_SVC;
                r.imm_value = 64'(w[20:5]);
            end else if ((w & MSK_EXC) == VAL_BRK) begin
                r.op_class  = OP_BRK;
                r.imm_value = 64'(w[20:5]);
            end else if (w == WORD_DMB) begin
                r.op_class = OP_DMB;
            end else if (w == WORD_DSB) begin
                r.op_class = OP_DSB;
            end else if (w == WORD_ISB) begin
                r.op_class = OP_ISB;
            end
            r.mem_disp    = disp[15:0];
            r.reencodable = (r.op_class != OP_OPAQUE);
            return r;
        endfunction

        function void note_request(logic [31:0] w, logic [63:0] pc);
            decode_entry_t e;
            e.word = w;
            e.pc   = pc;
            e.want = decode_a64(w, pc);
            pending_decodes = {pending_decodes, e};
            n_requests++;
        endfunction

        task report_mismatch(string what);
            n_errors++;
            if (n_errors <= MAX_REPORTED)
                $display("[%0t] decode mismatch: %s", $time, what);
        endtask

        task cmp_field(decode_entry_t e, string name, logic [63:0] got,
                       logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("word %h pc %h %s: got %h, want %h",
                                          e.word, e.pc, name, got, want));
        endtask

        task check_result(dec_result_t got);
            decode_entry_t e;
            if (pending_decodes.size() == 0) begin
                report_mismatch($sformatf("result class %0d with no request open",
                                          got.op_class));
                return;
            end
            e = pending_decodes.pop_front();
            n_checked++;
            class_seen[e.want.op_class] = 1'b1;
            cmp_field(e, "op_class",      got.op_class,      e.want.op_class);
            cmp_field(e, "dest_reg",      got.dest_reg,      e.want.dest_reg);
            cmp_field(e, "base_reg",      got.base_reg,      e.want.base_reg);
            cmp_field(e, "second_reg",    got.second_reg,    e.want.second_reg);
            cmp_field(e, "operand_bytes", got.operand_bytes, e.want.operand_bytes);
            cmp_field(e, "cond_code",     got.cond_code,     e.want.cond_code);
            cmp_field(e, "imm_value",     got.imm_value,     e.want.imm_value);
            cmp_field(e, "target_valid",  got.target_valid,  e.want.target_valid);
            cmp_field(e, "target_addr",   got.target_addr,   e.want.target_addr);
            cmp_field(e, "mem_disp",      got.mem_disp,      e.want.mem_disp);
            cmp_field(e, "addr_mode",     got.addr_mode,     e.want.addr_mode);
            cmp_field(e, "reencodable",   got.reencodable,   e.want.reencodable);
        endtask

    endclass

endpackage

### tb/sv/arm64_instruction_decoder_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// arm64_instruction_decoder_top_tb: self-checking bench for the A64 decoder
// Drives directed and shaped random instruction words with addresses through
// the valid/ready input, predicts every decoded record and checks each result
// in order, under three idle mixes, a long output stall and drain pauses.
// ============================================================================
module arm64_instruction_decoder_top_tb;

    import a64dec_pkg::*;
    import a64dec_tb_pkg::*;

    localparam int unsigned N_RANDOM        = 800;
    localparam int unsigned N_HOLD_ITEMS    = 40;
    localparam int unsigned HOLD_OFF_CYCLES = 64;
    localparam int unsigned TAIL_CYCLES     = 8;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned N_TEMPLATES     = 27;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;

    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [31:0]        s_instr_word = '0;
    logic [63:0]        s_pc_address = '0;

    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic [5:0]         m_op_class;
    logic [4:0]         m_dest_reg;
    logic [4:0]         m_base_reg;
    logic [4:0]         m_second_reg;
    logic [3:0]         m_operand_bytes;
    logic [3:0]         m_cond_code;
    logic [63:0]        m_imm_value;
    logic               m_target_valid;
    logic [63:0]        m_target_addr;
    logic signed [15:0] m_mem_disp;
    logic [1:0]         m_addr_mode;
    logic               m_reencodable;

    // Idle percentages of both sides, and a one-shot request for a long stall
    int unsigned src_idle_pct  = 0;
    int unsigned dst_idle_pct  = 0;
    int unsigned sink_hold_req = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned n_directed    = 0;

    decode_scoreboard sb = new();

    // 2 ns period: high phase, then low phase
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    arm64_instruction_decoder_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_instr_word    (s_instr_word),
        .s_pc_address    (s_pc_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_op_class      (m_op_class),
        .m_dest_reg      (m_dest_reg),
        .m_base_reg      (m_base_reg),
        .m_second_reg    (m_second_reg),
        .m_operand_bytes (m_operand_bytes),
        .m_cond_code     (m_cond_code),
        .m_imm_value     (m_imm_value),
        .m_target_valid  (m_target_valid),
        .m_target_addr   (m_target_addr),
        .m_mem_disp      (m_mem_disp),
        .m_addr_mode     (m_addr_mode),
        .m_reencodable   (m_reencodable)
    );

    // ------------------------------------------------------------------------
    // Address picker: mostly random, sometimes an extreme that makes targets
    // wrap or exercises the page alignment of adrp
    // ------------------------------------------------------------------------
    function automatic logic [63:0] pick_pc();
        logic [63:0] pc;
        case ($urandom_range(0, 15))
            0:       pc = 64'h0;
            1:       pc = '1;
            2:       pc = 64'h8000_0000_0000_0000;
            3:       pc = 64'h7FFF_FFFF_FFFF_FFFC;
            4:       pc = {$urandom, 20'h0, 12'hFFF};
            default: pc = {$urandom, $urandom};
        endcase
        return pc;
    endfunction

    // ------------------------------------------------------------------------
    // Offer one request: idle at random first, then hold valid and payload
    // until the edge at which ready is seen high. Called right after an edge,
    // so s_valid gets a single nonblocking write per time step.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [31:0] w, input logic [63:0] pc);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_instr_word <= w;
        s_pc_address <= pc;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Drop valid and wait until every predicted result has been delivered.
    // The first edge lets the monitor note the last accepted request.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_decodes.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Directed words: field extremes, every class and each decode corner
    // ------------------------------------------------------------------------
    task automatic run_directed();
        // all-zero and all-one words are both opaque
        send_word(32'h0000_0000, 64'h0);
        send_word(32'hFFFF_FFFF, '1);
        // adr/adrp: offset minus one, most positive offset, wrap, page align
        send_word(32'h70FF_FFE0, 64'h0);
        send_word(32'h707F_FFE0, '1);
        send_word(32'hF0FF_FFFF, 64'h0000_0000_0000_0ABC);
        send_word(32'hB000_0000, '1);
        // b/bl: offset minus one, and the most negative of the 26-bit range
        send_word(32'h15FF_FFFF, '1);
        send_word(32'h9600_0000, 64'h0);
        // b.cond, plus the bit-4-set near miss that must stay opaque
        send_word(32'h54FF_FFEF, pick_pc());
        send_word(32'h5400_0000, pick_pc());
        send_word(32'h5400_0010, pick_pc());
        // compare and test branches, 32 and 64 bit
        send_word(32'h3400_0000, pick_pc());
        send_word(32'hB5FF_FFFF, 64'h0);
        send_word(32'h3600_0000, pick_pc());
        send_word(32'hB7FF_FFFF, 64'h0);
        // register branches
        send_word(32'hD65F_03C0, pick_pc());
        send_word(32'hD61F_0220, pick_pc());
        send_word(32'hD63F_03E0, pick_pc());
        // add/sub immediate: max imm12, shift bit ignored, subs folds to sub
        send_word(32'h913F_FC00, pick_pc());
        send_word(32'h917F_FC00, pick_pc());
        send_word(32'h7100_0000, pick_pc());
        // register ALU forms: adds/subs and ands fold into add/sub/and
        send_word(32'h8B02_0020, pick_pc());
        send_word(32'hEB1F_03FF, pick_pc());
        send_word(32'hEA00_0000, pick_pc());
        send_word(32'hAA01_03E0, pick_pc());
        send_word(32'h4A00_0000, pick_pc());
        // conditional select: csinc to csel, csneg to csinv
        send_word(32'h9A80_0000, pick_pc());
        send_word(32'h1A9F_17E0, pick_pc());
        send_word(32'hDA9F_13E0, pick_pc());
        send_word(32'h5A80_F400, pick_pc());
        // move wide: hw 3 in both widths, and the opc 01 hole
        send_word(32'h1280_0000, pick_pc());
        send_word(32'hD2FF_FFE0, pick_pc());
        send_word(32'hF2A0_0020, pick_pc());
        send_word(32'h52FF_FFE0, pick_pc());
        send_word(32'h3280_0000, pick_pc());
        // unscaled: post, pre, negative offset, mode 10 as offset
        send_word(32'h3800_0400, pick_pc());
        send_word(32'hF840_0C00, pick_pc());
        send_word(32'hF85F_F3E0, pick_pc());
        send_word(32'h7800_0800, pick_pc());
        // scaled: zero and largest offset
        send_word(32'hF900_0000, pick_pc());
        send_word(32'hF97F_FFFF, pick_pc());
        send_word(32'h3940_0000, pick_pc());
        // pairs: offset, post, pre with negative offset
        send_word(32'h2900_0000, pick_pc());
        send_word(32'hA8C0_0000, pick_pc());
        send_word(32'hA9FF_FFFF, pick_pc());
        // multiply and divide; 32-bit mul does not match
        send_word(32'h9B02_7C20, pick_pc());
        send_word(32'h9AC2_0820, pick_pc());
        send_word(32'h9AC2_0C20, pick_pc());
        send_word(32'h1B00_7C00, pick_pc());
        // hints: nop, wfe, wfi, and another hint that decodes as nop
        send_word(32'hD503_201F, pick_pc());
        send_word(32'hD503_205F, pick_pc());
        send_word(32'hD503_207F, pick_pc());
        send_word(32'hD503_209F, pick_pc());
        // exceptions with zero and max immediate, then barriers
        send_word(32'hD400_0001, pick_pc());
        send_word(32'hD41F_FFE1, pick_pc());
        send_word(32'hD420_0000, pick_pc());
        send_word(32'hD43F_FFE0, pick_pc());
        send_word(32'hD503_3BBF, pick_pc());
        send_word(32'hD503_3F9F, pick_pc());
        send_word(32'hD503_3FDF, pick_pc());
    endtask

    // ------------------------------------------------------------------------
    // Random words: mostly a random encoding template with random free bits,
    // some near misses with one fixed bit flipped, the rest raw noise
    // ------------------------------------------------------------------------
    task automatic run_random(input int unsigned count);
        logic [31:0] msk;
        logic [31:0] val;
        logic [31:0] w;
        int unsigned pick;
        int unsigned flavor;
        int unsigned b;
        for (int unsigned i = 0; i < count; i++) begin
            pick   = $urandom_range(0, N_TEMPLATES - 1);
            flavor = $urandom_range(0, 99);
            case (pick)
                0:  {msk, val} = {MSK_ADR,    VAL_ADR};
                1:  {msk, val} = {MSK_B,      VAL_B};
                2:  {msk, val} = {MSK_BCOND,  VAL_BCOND};
                3:  {msk, val} = {MSK_CB,     VAL_CB};
                4:  {msk, val} = {MSK_CB,     VAL_TB};
                5:  {msk, val} = {MSK_BRREG,  VAL_RET};
                6:  {msk, val} = {MSK_BRREG,  VAL_BR};
                7:  {msk, val} = {MSK_BRREG,  VAL_BLR};
                // add/sub immediate shares the adr mask
                8:  {msk, val} = {MSK_ADR,    VAL_ADDI};
                9:  {msk, val} = {MSK_ALUREG, VAL_ADDR};
                10: {msk, val} = {MSK_ALUREG, VAL_LOGIC};
                11: {msk, val} = {MSK_CSEL,   VAL_CSEL};
                12: {msk, val} = {MSK_MOVW,   VAL_MOVW};
                13: {msk, val} = {MSK_LDUR,   VAL_LDUR};
                14: {msk, val} = {MSK_LDR,    VAL_LDR};
                15: {msk, val} = {MSK_LDP,    VAL_LDP};
                16: {msk, val} = {MSK_MULDIV, VAL_MUL};
                17: {msk, val} = {MSK_MULDIV, VAL_SDIV};
                18: {msk, val} = {MSK_MULDIV, VAL_UDIV};
                19: {msk, val} = {32'hFFFF_FFFF, WORD_WFE};
                20: {msk, val} = {32'hFFFF_FFFF, WORD_WFI};
                21: {msk, val} = {MSK_BRREG,  VAL_HINT};
                22: {msk, val} = {MSK_EXC,    VAL_SVC};
                23: {msk, val} = {MSK_EXC,    VAL_BRK};
                24: {msk, val} = {32'hFFFF_FFFF, WORD_DMB};
                25: {msk, val} = {32'hFFFF_FFFF, WORD_DSB};
                default: {msk, val} = {32'hFFFF_FFFF, WORD_ISB};
            endcase
            w = ($urandom & ~msk) | val;
            if (flavor >= 90) begin
                w = $urandom;
            end else if (flavor >= 80) begin
                // near miss: flip one bit the encoding fixes
                b = $urandom_range(0, 31);
                while (!msk[b])
                    b = $urandom_range(0, 31);
                w[b] = ~w[b];
            end
            send_word(w, pick_pc());
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready at dst_idle_pct, or a long counted stall when
    // the stimulus asks for one
    // ------------------------------------------------------------------------
    initial begin : sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold_req != 0) begin
                stall_left    = sink_hold_req;
                sink_hold_req = 0;
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= dst_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both handshakes at the edge; check results before
    // noting the request accepted at the same edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        dec_result_t observed;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                observed.op_class      = op_class_t'(m_op_class);
                observed.dest_reg      = m_dest_reg;
                observed.base_reg      = m_base_reg;
                observed.second_reg    = m_second_reg;
                observed.operand_bytes = m_operand_bytes;
                observed.cond_code     = m_cond_code;
                observed.imm_value     = m_imm_value;
                observed.target_valid  = m_target_valid;
                observed.target_addr   = m_target_addr;
                observed.mem_disp      = m_mem_disp;
                observed.addr_mode     = addr_mode_t'(m_addr_mode);
                observed.reencodable   = m_reencodable;
                sb.check_result(observed);
            end
            if (s_valid && s_ready)
                sb.note_request(s_instr_word, s_pc_address);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no handshake happens for too long
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results open",
                     WATCHDOG_LIMIT, sb.pending_decodes.size());
            $display("arm64_instruction_decoder_top_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned n_classes;
        int unsigned per_phase;
        per_phase = N_RANDOM / 3;

        // hold reset, then release it once
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words with both sides always ready
        run_directed();
        wait_drained();
        n_directed = sb.n_requests;

        // sender idles lightly, receiver heavily
        src_idle_pct = 21;
        dst_idle_pct = 83;
        run_random(per_phase);
        wait_drained();

        // swap the idle mix
        src_idle_pct = 83;
        dst_idle_pct = 21;
        run_random(per_phase);
        wait_drained();

        // no idling: stall the receiver for a long stretch while requests keep
        // coming so the input backs up, then stream the rest at full rate
        src_idle_pct  = 0;
        dst_idle_pct  = 0;
        sink_hold_req = HOLD_OFF_CYCLES;
        run_random(N_HOLD_ITEMS);
        run_random(N_RANDOM - 2 * per_phase - N_HOLD_ITEMS);
        wait_drained();

        // let any stray result surface before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.pending_decodes.size() != 0)
            sb.report_mismatch($sformatf("%0d requests never produced a result",
                                         sb.pending_decodes.size()));

        n_classes = 0;
        foreach (sb.class_seen[k])
            if (sb.class_seen[k])
                n_classes++;
        $display("Decoded %0d requests (%0d directed) over three idle mixes, a %0d-cycle",
                 sb.n_requests, n_directed, HOLD_OFF_CYCLES);
        $display("output stall and drain pauses; %0d checked, %0d of 40 classes, %0d errors.",
                 sb.n_checked, n_classes, sb.n_errors);

        if (sb.n_errors == 0) begin
            $display("arm64_instruction_decoder_top_tb: PASS");
        end else begin
            $display("arm64_instruction_decoder_top_tb: FAIL");
        end
        $finish;
    end

endmodule
